@@ src/spwt_pkg.sv @@
package spwt_pkg;

  localparam int unsigned MAX_PATTERN = 16;
  localparam int unsigned LEN_W = 5;
  localparam int unsigned TIMEOUT_W = 32;
  localparam int unsigned PATTERN_W = 8 * MAX_PATTERN;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd2000;
  localparam logic [LEN_W-1:0] LENGTH_RESET = 5'd1;

  typedef enum logic [1:0] {
    REG_PATTERN_LOW  = 2'd0,
    REG_PATTERN_HIGH = 2'd1,
    REG_LENGTH       = 2'd2,
    REG_TIMEOUT      = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_WAITING   = 2'd1,
    PH_FOUND     = 2'd2,
    PH_TIMED_OUT = 2'd3
  } phase_t;

  typedef struct packed {
    logic [PATTERN_W-1:0] pattern;
    logic [LEN_W-1:0]     used_len;
    logic [TIMEOUT_W-1:0] timeout;
  } cfg_t;

  typedef struct packed {
    op_t        opcode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    phase_t           status;
    logic [LEN_W-1:0] position;
  } res_t;

endpackage

@@ src/spwt_cfg_regs.sv @@
module spwt_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  output spwt_pkg::cfg_t      cfg
);

  logic [63:0] pattern_low;
  logic [63:0] pattern_high;
  logic [spwt_pkg::LEN_W-1:0] pattern_length;
  logic [spwt_pkg::TIMEOUT_W-1:0] timeout_ticks;
  logic cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= spwt_pkg::LENGTH_RESET;
      timeout_ticks  <= spwt_pkg::TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (spwt_pkg::reg_idx_t'(cfg_index))
        spwt_pkg::REG_PATTERN_LOW:  pattern_low    <= cfg_data;
        spwt_pkg::REG_PATTERN_HIGH: pattern_high   <= cfg_data;
        spwt_pkg::REG_LENGTH:       pattern_length <= cfg_data[spwt_pkg::LEN_W-1:0];
        spwt_pkg::REG_TIMEOUT:      timeout_ticks  <= cfg_data[spwt_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.pattern = {pattern_high, pattern_low};
    cfg.timeout = timeout_ticks;
    if (pattern_length == '0) begin
      cfg.used_len = spwt_pkg::LEN_W'(1);
    end else if (pattern_length > spwt_pkg::LEN_W'(spwt_pkg::MAX_PATTERN)) begin
      cfg.used_len = spwt_pkg::LEN_W'(spwt_pkg::MAX_PATTERN);
    end else begin
      cfg.used_len = pattern_length;
    end
  end

endmodule

@@ src/spwt_match_core.sv @@
module spwt_match_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  spwt_pkg::item_t   item,
  input  spwt_pkg::cfg_t    cfg,
  output spwt_pkg::res_t    res
);

  spwt_pkg::phase_t phase;
  spwt_pkg::phase_t phase_next;
  logic [spwt_pkg::LEN_W-1:0] position;
  logic [spwt_pkg::LEN_W-1:0] position_next;
  logic [spwt_pkg::TIMEOUT_W-1:0] elapsed;
  logic [spwt_pkg::TIMEOUT_W-1:0] elapsed_next;
  logic [spwt_pkg::TIMEOUT_W-1:0] elapsed_inc;
  logic [spwt_pkg::LEN_W-1:0] pos_inc;
  logic [7:0] pos_byte;
  logic [7:0] first_byte;
  logic byte_hit;
  logic first_hit;
  logic waiting;

  assign waiting     = (phase == spwt_pkg::PH_WAITING);
  assign pos_byte    = cfg.pattern[8*position[3:0] +: 8];
  assign first_byte  = cfg.pattern[7:0];
  assign byte_hit    = (item.rx_byte == pos_byte);
  assign first_hit   = (item.rx_byte == first_byte);
  assign pos_inc     = position + spwt_pkg::LEN_W'(1);
  assign elapsed_inc = (elapsed == '1) ? elapsed : elapsed + spwt_pkg::TIMEOUT_W'(1);

  always_comb begin
    phase_next = phase;
    case (item.opcode)
      spwt_pkg::OP_START: begin
        phase_next = (cfg.timeout == '0) ? spwt_pkg::PH_TIMED_OUT : spwt_pkg::PH_WAITING;
      end
      spwt_pkg::OP_TICK: begin
        if (waiting && elapsed_inc >= cfg.timeout) begin
          phase_next = spwt_pkg::PH_TIMED_OUT;
        end
      end
      spwt_pkg::OP_BYTE: begin
        if (waiting && byte_hit && pos_inc >= cfg.used_len) begin
          phase_next = spwt_pkg::PH_FOUND;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    position_next = position;
    elapsed_next  = elapsed;
    case (item.opcode)
      spwt_pkg::OP_START: begin
        position_next = '0;
        elapsed_next  = '0;
      end
      spwt_pkg::OP_TICK: begin
        if (waiting) begin
          elapsed_next = elapsed_inc;
        end
      end
      spwt_pkg::OP_BYTE: begin
        if (waiting) begin
          if (byte_hit) begin
            position_next = (pos_inc >= cfg.used_len) ? cfg.used_len : pos_inc;
          end else begin
            position_next = first_hit ? spwt_pkg::LEN_W'(1) : '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.status   = phase_next;
    res.position = position_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= spwt_pkg::PH_IDLE;
      position <= '0;
      elapsed  <= '0;
    end else if (fire) begin
      phase    <= phase_next;
      position <= position_next;
      elapsed  <= elapsed_next;
    end
  end

  a_position_range: assert property (@(posedge clk) disable iff (rst)
    position <= spwt_pkg::LEN_W'(spwt_pkg::MAX_PATTERN))
    else $error("match position beyond pattern size");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    fire && item.opcode == spwt_pkg::OP_START |=>
      position == '0 && elapsed == '0 &&
      (phase == spwt_pkg::PH_WAITING || phase == spwt_pkg::PH_TIMED_OUT))
    else $error("start did not clear the wait");

  a_found_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == spwt_pkg::PH_FOUND |-> position != '0)
    else $error("found with no bytes matched");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    phase == spwt_pkg::PH_IDLE |-> position == '0 && elapsed == '0)
    else $error("state not clear while idle");

  a_hold_without_fire: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(elapsed) && $stable(position))
    else $error("state moved without a transfer");

endmodule

@@ src/stream_pattern_wait_with_timeout_core.sv @@
// Streaming pattern wait with timeout.
// Input channel (in_valid, in_stall, opcode, rx_byte): a transfer happens on
// a rising edge with in_valid high and in_stall low. Opcode 0 carries a
// received byte, 1 a timer tick, 2 starts a new wait, 3 changes nothing.
// Output channel (out_valid, out_stall, wait_status, match_position): one
// result per input transfer, in order, giving the status and match position
// after that item.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): index 0
// pattern bytes 0-7, 1 pattern bytes 8-15, 2 pattern length, 3 timeout in
// ticks. cfg_ready is always high; write only while no items are in flight.
// The item waits in an input register and its result is loaded into a result
// register once the output is not stalled. Throughput: one item per cycle
// while the output does not stall; the byte compare and the 32-bit tick
// increment sit between those two registers.
// A stalled result holds; one further item is taken into the input register
// and in_stall then rises until the result is taken.
// Reset (rst, synchronous): idle status, position and tick count cleared,
// pattern zero, length 1, timeout 2000, both stages empty.
module stream_pattern_wait_with_timeout_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  wait_status,
  output logic [4:0]  match_position,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  spwt_pkg::cfg_t  cfg;
  spwt_pkg::item_t in_item;
  spwt_pkg::res_t  res;
  logic in_reg_valid;
  logic in_take;
  logic load_out;

  spwt_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  spwt_match_core u_match_core (
    .clk  (clk),
    .rst  (rst),
    .fire (load_out),
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

  assign load_out = in_reg_valid && (!out_valid || !out_stall);
  assign in_stall = in_reg_valid && !load_out;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else begin
      in_reg_valid <= in_take || (in_reg_valid && !load_out);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item.opcode  <= spwt_pkg::op_t'(opcode);
      in_item.rx_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      wait_status    <= res.status;
      match_position <= res.position;
    end
  end

  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_reg_valid && out_valid && out_stall)
    else $error("input stalled with room downstream");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid)
    else $error("processed item produced no result");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    in_reg_valid && !load_out |=> in_reg_valid)
    else $error("pending item lost");

endmodule
